@@ hdl/fcm_pkg.sv @@
// Shared types and constants for the frame capture mirror.
// Used by fcm_ctrl, fcm_store and frame_capture_mirror_top; no dependencies.
package fcm_pkg;

	// Frame store geometry.
	localparam int unsigned MAX_WIDTH   = 512;
	localparam int unsigned MAX_HEIGHT  = 512;
	localparam int unsigned STORE_WORDS = MAX_WIDTH * MAX_HEIGHT;
	localparam int unsigned MEM_AW      = $clog2(STORE_WORDS);

	// Field widths.
	localparam int unsigned DIM_W   = 10;
	localparam int unsigned COORD_W = 16;
	localparam int unsigned PIX_W   = 16;
	localparam int unsigned POS_W   = 9;
	localparam int unsigned ROWS_W  = 11;
	localparam int unsigned CFG_IDX_W = 2;

	// Linear address width: row times stride plus column, before the range check.
	localparam int unsigned PROD_W = (MEM_AW > 2 * DIM_W) ? MEM_AW + 1 : 2 * DIM_W + 1;

	// Configuration register indexes and reset values.
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [DIM_W-1:0] WIDTH_RESET  = 10'd320;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 10'd240;

	typedef enum logic [2:0] {
		OP_REQUEST = 3'd0,
		OP_ARM     = 3'd1,
		OP_PIXEL   = 3'd2,
		OP_THAW    = 3'd3,
		OP_READ    = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		PH_IDLE      = 2'd0,
		PH_REQUESTED = 2'd1,
		PH_ARMING    = 2'd2,
		PH_READY     = 2'd3
	} phase_t;

	// One decoded item handed from the control front end to the store pipeline.
	typedef struct packed {
		logic               acc;
		logic               wr;
		logic               rd;
		logic [DIM_W-1:0]   x;
		logic [DIM_W-1:0]   y;
		logic [PIX_W-1:0]   data;
		phase_t             phase;
		logic               ready;
		logic               busy;
	} issue_t;

endpackage

@@ hdl/frame_capture_mirror_top.sv @@
// Top level of the frame capture mirror: configuration registers and handshakes.
// Depends on fcm_pkg, fcm_ctrl and fcm_store.

// The block takes one item per clock while in_stall is low and returns one result
// per item, in order; each item passes the stage-one register, where its address is
// formed, and then the result register, and the rate is set by the single frame store
// port that each pixel write or read uses once. After reset the store is zeroed by a
// clearing pass over all MAX_WIDTH times MAX_HEIGHT words, one word per cycle, during
// which in_stall is high; configuration writes are taken at any time and must only be issued
// while no item is in flight.
module frame_capture_mirror_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [fcm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [fcm_pkg::DIM_W-1:0]            cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [2:0]                           operation,
	input  logic signed [15:0]                   rect_left,
	input  logic signed [15:0]                   rect_top,
	input  logic signed [15:0]                   rect_right,
	input  logic signed [15:0]                   rect_bottom,
	input  logic [15:0]                          pixel_value,
	input  logic                                 pixel_last,
	input  logic [8:0]                           read_x,
	input  logic [8:0]                           read_y,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 accepted,
	output logic [1:0]                           capture_state,
	output logic                                 capture_ready,
	output logic                                 capture_busy,
	output logic [15:0]                          read_data
);
	import fcm_pkg::*;

	logic [DIM_W-1:0] width_q, height_q;
	logic             take, hold;
	issue_t           item;

	// Configuration registers take every write.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH:  width_q  <= cfg_data;
				CFG_FRAME_HEIGHT: height_q <= cfg_data;
				default:          ;
			endcase
		end
	end

	// Input transfer.
	assign in_stall = hold;
	assign take     = in_valid && !hold;

	fcm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.operation    (operation),
		.rect_left    (rect_left),
		.rect_top     (rect_top),
		.rect_right   (rect_right),
		.rect_bottom  (rect_bottom),
		.pixel_value  (pixel_value),
		.pixel_last   (pixel_last),
		.read_x       (read_x),
		.read_y       (read_y),
		.frame_width  (width_q),
		.frame_height (height_q),
		.item         (item)
	);

	fcm_store u_store (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.item          (item),
		.frame_width   (width_q),
		.out_stall     (out_stall),
		.hold          (hold),
		.out_valid     (out_valid),
		.accepted      (accepted),
		.capture_state (capture_state),
		.capture_ready (capture_ready),
		.capture_busy  (capture_busy),
		.read_data     (read_data)
	);

endmodule

@@ hdl/fcm_ctrl.sv @@
// Capture state machine, rectangle cursor, clipping and row counting.
// Depends on fcm_pkg; produces one decoded item per transfer.
module fcm_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            take,
	input  logic [2:0]                      operation,
	input  logic signed [15:0]              rect_left,
	input  logic signed [15:0]              rect_top,
	input  logic signed [15:0]              rect_right,
	input  logic signed [15:0]              rect_bottom,
	input  logic [15:0]                     pixel_value,
	input  logic                            pixel_last,
	input  logic [8:0]                      read_x,
	input  logic [8:0]                      read_y,
	input  logic [fcm_pkg::DIM_W-1:0]       frame_width,
	input  logic [fcm_pkg::DIM_W-1:0]       frame_height,
	output fcm_pkg::issue_t                 item
);
	import fcm_pkg::*;

	phase_t              phase_q, phase_n;
	logic [ROWS_W-1:0]   rows_q, rows_n;
	logic [COORD_W-1:0]  col_q, col_n, row_q, row_n;
	logic                open_q, open_n;

	op_t                 op;
	logic [COORD_W-1:0]  col_base, row_base;
	logic signed [17:0]  x_pos, y_pos, x_lo, y_lo, x_hi, y_hi, w_s, h_s, span, row_cnt;
	logic                rect_empty, in_rect, clip_ok, col_wrap, armed, pix_store;
	logic [ROWS_W:0]     rows_sum;
	logic [ROWS_W-1:0]   rows_sat;
	logic                rows_done, rd_ok;

	assign op = op_t'(operation);

	// Pixel position relative to the frame, and the clipped rectangle.
	always_comb begin
		col_base   = open_q ? col_q : '0;
		row_base   = open_q ? row_q : '0;
		w_s        = $signed({8'b0, frame_width});
		h_s        = $signed({8'b0, frame_height});
		x_pos      = 18'(rect_left) + $signed({2'b00, col_base});
		y_pos      = 18'(rect_top) + $signed({2'b00, row_base});
		x_lo       = rect_left[15] ? '0 : 18'(rect_left);
		y_lo       = rect_top[15] ? '0 : 18'(rect_top);
		x_hi       = (18'(rect_right) >= w_s) ? w_s - 18'sd1 : 18'(rect_right);
		y_hi       = (18'(rect_bottom) >= h_s) ? h_s - 18'sd1 : 18'(rect_bottom);
		span       = 18'(rect_right) - 18'(rect_left);
		rect_empty = (rect_right < rect_left) || (rect_bottom < rect_top);
		in_rect    = (x_pos >= x_lo) && (x_pos <= x_hi) && (y_pos >= y_lo) && (y_pos <= y_hi);
		clip_ok    = (x_hi >= x_lo) && (y_hi >= y_lo);
		col_wrap   = $signed({2'b00, col_base}) >= span;
		armed      = phase_q == PH_ARMING;
		pix_store  = armed && !rect_empty && in_rect;
		row_cnt    = y_hi - y_lo + 18'sd1;
		rows_sum   = {1'b0, rows_q} + {1'b0, row_cnt[ROWS_W-1:0]};
		rows_sat   = rows_sum[ROWS_W] ? {ROWS_W{1'b1}} : rows_sum[ROWS_W-1:0];
		rows_done  = rows_sat >= {1'b0, frame_height};
		rd_ok      = ({1'b0, read_x} < frame_width) && ({1'b0, read_y} < frame_height);
	end

	// Cursor and row count update.
	always_comb begin
		col_n  = col_q;
		row_n  = row_q;
		open_n = open_q;
		rows_n = rows_q;
		case (op)
			OP_ARM: begin
				if (phase_q == PH_REQUESTED) rows_n = '0;
			end
			OP_PIXEL: begin
				if (rect_empty) begin
					col_n  = '0;
					row_n  = '0;
					open_n = 1'b0;
				end else begin
					open_n = 1'b1;
					if (col_wrap) begin
						col_n = '0;
						row_n = row_base + 16'd1;
					end else begin
						col_n = col_base + 16'd1;
						row_n = row_base;
					end
					if (pixel_last) begin
						open_n = 1'b0;
						col_n  = '0;
						row_n  = '0;
						if (armed && clip_ok) rows_n = rows_sat;
					end
				end
			end
			default: ;
		endcase
	end

	// Capture state machine: next state.
	always_comb begin
		phase_n = phase_q;
		unique case (op)
			OP_REQUEST: if (phase_q == PH_IDLE) phase_n = PH_REQUESTED;
			OP_ARM:     if (phase_q == PH_REQUESTED) phase_n = PH_ARMING;
			OP_PIXEL: begin
				if (armed && !rect_empty && pixel_last && clip_ok && rows_done)
					phase_n = PH_READY;
			end
			OP_THAW:    phase_n = PH_IDLE;
			default:    ;
		endcase
	end

	// Capture state machine: outputs toward the store pipeline.
	always_comb begin
		item       = '0;
		item.phase = phase_n;
		item.ready = phase_n == PH_READY;
		item.busy  = phase_n != PH_IDLE;
		item.data  = pixel_value;
		unique case (op)
			OP_REQUEST: item.acc = phase_q == PH_IDLE;
			OP_ARM:     item.acc = phase_q == PH_REQUESTED;
			OP_PIXEL: begin
				item.wr = pix_store;
				item.x  = x_pos[DIM_W-1:0];
				item.y  = y_pos[DIM_W-1:0];
			end
			OP_THAW:    item.acc = 1'b1;
			OP_READ: begin
				item.rd = rd_ok;
				item.x  = {1'b0, read_x};
				item.y  = {1'b0, read_y};
			end
			default:    ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			rows_q  <= '0;
			col_q   <= '0;
			row_q   <= '0;
			open_q  <= 1'b0;
		end else if (take) begin
			phase_q <= phase_n;
			rows_q  <= rows_n;
			col_q   <= col_n;
			row_q   <= row_n;
			open_q  <= open_n;
		end
	end

endmodule

@@ hdl/fcm_store.sv @@
// Frame store memory with its address stage, result register and clearing pass.
// Depends on fcm_pkg; takes decoded accesses from fcm_ctrl.
module fcm_store (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        take,
	input  fcm_pkg::issue_t             item,
	input  logic [fcm_pkg::DIM_W-1:0]   frame_width,
	input  logic                        out_stall,
	output logic                        hold,
	output logic                        out_valid,
	output logic                        accepted,
	output logic [1:0]                  capture_state,
	output logic                        capture_ready,
	output logic                        capture_busy,
	output logic [15:0]                 read_data
);
	import fcm_pkg::*;

	logic [PIX_W-1:0]    mem [STORE_WORDS];

	logic                clearing_q;
	logic [MEM_AW-1:0]   clr_q;

	logic                v_s1, v_s2;
	issue_t              it_s1;
	logic [PROD_W-1:0]   addr_s1;
	logic                in_store_s1, adv;

	logic                acc_s2, rd_s2, ready_s2, busy_s2;
	phase_t              phase_s2;
	logic [PIX_W-1:0]    rdata_s2;

	logic                mem_we;
	logic [MEM_AW-1:0]   mem_wa;
	logic [PIX_W-1:0]    mem_wd;

	// Address stage: row times stride plus column.
	assign addr_s1     = PROD_W'(it_s1.y) * PROD_W'(frame_width) + PROD_W'(it_s1.x);
	assign in_store_s1 = 32'(addr_s1) < STORE_WORDS;
	assign adv         = v_s1 && (!v_s2 || !out_stall);
	assign hold        = clearing_q || (v_s1 && !adv);

	// Write port: the clearing pass owns it until the whole store is zero.
	always_comb begin
		mem_we = clearing_q || (adv && it_s1.wr && in_store_s1);
		mem_wa = clearing_q ? clr_q : addr_s1[MEM_AW-1:0];
		mem_wd = clearing_q ? '0 : it_s1.data;
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (adv && it_s1.rd && in_store_s1) rdata_s2 <= mem[addr_s1[MEM_AW-1:0]];
	end

	// Clearing pass after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == MEM_AW'(STORE_WORDS - 1)) clearing_q <= 1'b0;
		end
	end

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (take) v_s1 <= 1'b1;
			else if (adv) v_s1 <= 1'b0;
			if (adv) v_s2 <= 1'b1;
			else if (!out_stall) v_s2 <= 1'b0;
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		if (take) it_s1 <= item;
		if (adv) begin
			acc_s2   <= it_s1.acc || ((it_s1.wr || it_s1.rd) && in_store_s1);
			rd_s2    <= it_s1.rd && in_store_s1;
			phase_s2 <= it_s1.phase;
			ready_s2 <= it_s1.ready;
			busy_s2  <= it_s1.busy;
		end
	end

	// Result register drives the output channel.
	assign out_valid     = v_s2;
	assign accepted      = acc_s2;
	assign capture_state = phase_s2;
	assign capture_ready = ready_s2;
	assign capture_busy  = busy_s2;
	assign read_data     = rd_s2 ? rdata_s2 : '0;

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for frame_capture_mirror_top: capture requests, pixel
// streams, thaws and reads, checked in order against a built-in model of the block.
// Depends on fcm_pkg and the RTL of frame_capture_mirror_top only.
`timescale 1ns / 100ps

module tb;
	import fcm_pkg::*;

	// Operation codes that the block must ignore.
	localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
	// Register index that maps to nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

	localparam int IDLE_PCT     = 11;
	localparam int RANDOM_ITEMS = 1150;
	// The store clearing pass after reset holds off input over the whole store.
	localparam int QUIET_LIMIT  = 1000000;
	localparam int TAIL_CYCLES  = 8;

	typedef struct {
		logic [2:0]          op;
		logic signed [15:0]  left;
		logic signed [15:0]  top;
		logic signed [15:0]  right;
		logic signed [15:0]  bottom;
		logic [15:0]         value;
		logic                last;
		logic [8:0]          rx;
		logic [8:0]          ry;
	} frame_item_t;

	typedef struct {
		bit        acc;
		phase_t    st;
		bit        rdy;
		bit        busy;
		bit [15:0] data;
	} status_t;

	typedef struct {
		frame_item_t it;
		bit          typed;
		status_t     fixed;
	} plan_row_t;

	logic                 clk;
	logic                 arst_n      = 1'b0;
	logic                 cfg_valid   = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index   = CFG_FRAME_WIDTH;
	logic [DIM_W-1:0]     cfg_data    = '0;
	logic                 in_valid    = 1'b0;
	logic                 in_stall;
	logic [2:0]           operation   = OP_REQUEST;
	logic signed [15:0]   rect_left   = '0;
	logic signed [15:0]   rect_top    = '0;
	logic signed [15:0]   rect_right  = '0;
	logic signed [15:0]   rect_bottom = '0;
	logic [15:0]          pixel_value = '0;
	logic                 pixel_last  = 1'b0;
	logic [8:0]           read_x      = '0;
	logic [8:0]           read_y      = '0;
	logic                 out_valid;
	logic                 out_stall   = 1'b0;
	logic                 accepted;
	logic [1:0]           capture_state;
	logic                 capture_ready;
	logic                 capture_busy;
	logic [15:0]          read_data;

	frame_capture_mirror_top DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .operation(operation),
		.rect_left(rect_left), .rect_top(rect_top), .rect_right(rect_right),
		.rect_bottom(rect_bottom), .pixel_value(pixel_value), .pixel_last(pixel_last),
		.read_x(read_x), .read_y(read_y),
		.out_valid(out_valid), .out_stall(out_stall), .accepted(accepted),
		.capture_state(capture_state), .capture_ready(capture_ready),
		.capture_busy(capture_busy), .read_data(read_data)
	);

	// Model state of the capture machine and its frame store.
	logic [DIM_W-1:0] mirror_width  = WIDTH_RESET;
	logic [DIM_W-1:0] mirror_height = HEIGHT_RESET;
	phase_t           mirror_phase  = PH_IDLE;
	bit [ROWS_W-1:0]  rows_seen     = '0;
	bit [15:0]        cur_col       = '0;
	bit [15:0]        cur_row       = '0;
	bit               rect_active   = 1'b0;
	bit [15:0]        mirror_store [STORE_WORDS];

	status_t    expected_status [$];
	status_t    no_status;
	plan_row_t  opening_plan [$];
	bit         failed       = 1'b0;
	bit         idle_on      = 1'b1;
	bit         counting     = 1'b0;
	int         random_items = 0;
	int         quiet_cycles = 0;

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// One pixel item: clip to the frame, store while arming, advance the cursor.
	function automatic bit mirror_pixel(frame_item_t it);
		int lf, tp, rt, bt, w, h, x1, y1, x2, y2, x, y, sum;
		bit wrote;
		lf = int'(it.left);
		tp = int'(it.top);
		rt = int'(it.right);
		bt = int'(it.bottom);
		w = int'(mirror_width);
		h = int'(mirror_height);
		wrote = 1'b0;
		if (rt < lf || bt < tp) begin
			cur_col = '0;
			cur_row = '0;
			rect_active = 1'b0;
			return 1'b0;
		end
		if (!rect_active) begin
			cur_col = '0;
			cur_row = '0;
			rect_active = 1'b1;
		end
		x1 = (lf < 0) ? 0 : lf;
		y1 = (tp < 0) ? 0 : tp;
		x2 = (rt >= w) ? w - 1 : rt;
		y2 = (bt >= h) ? h - 1 : bt;
		x = lf + int'(cur_col);
		y = tp + int'(cur_row);
		if (mirror_phase == PH_ARMING && x >= x1 && x <= x2 && y >= y1 && y <= y2) begin
			if (y * w + x < STORE_WORDS) begin
				mirror_store[y * w + x] = it.value;
				wrote = 1'b1;
			end
		end
		// Raster walk: wrap to the next row after the right edge.
		if (int'(cur_col) >= rt - lf) begin
			cur_col = '0;
			cur_row = cur_row + 16'd1;
		end else begin
			cur_col = cur_col + 16'd1;
		end
		if (it.last) begin
			rect_active = 1'b0;
			cur_col = '0;
			cur_row = '0;
			if (mirror_phase == PH_ARMING && x2 >= x1 && y2 >= y1) begin
				sum = int'(rows_seen) + (y2 - y1 + 1);
				rows_seen = (sum > 2047) ? 11'd2047 : ROWS_W'(sum);
				if (rows_seen >= mirror_height)
					mirror_phase = PH_READY;
			end
		end
		return wrote;
	endfunction

	// Status that the block reports for one item, updating the model state.
	function automatic status_t mirror_step(frame_item_t it);
		status_t r;
		int addr;
		r.acc = 1'b0;
		r.data = '0;
		case (it.op)
			OP_REQUEST: begin
				if (mirror_phase == PH_IDLE) begin
					mirror_phase = PH_REQUESTED;
					r.acc = 1'b1;
				end
			end
			OP_ARM: begin
				if (mirror_phase == PH_REQUESTED) begin
					rows_seen = '0;
					mirror_phase = PH_ARMING;
					r.acc = 1'b1;
				end
			end
			OP_PIXEL: r.acc = mirror_pixel(it);
			OP_THAW: begin
				mirror_phase = PH_IDLE;
				r.acc = 1'b1;
			end
			OP_READ: begin
				if (it.rx < mirror_width && it.ry < mirror_height) begin
					addr = int'(it.ry) * int'(mirror_width) + int'(it.rx);
					if (addr < STORE_WORDS) begin
						r.data = mirror_store[addr];
						r.acc = 1'b1;
					end
				end
			end
			default: ;
		endcase
		r.st = mirror_phase;
		r.rdy = (mirror_phase == PH_READY);
		r.busy = (mirror_phase != PH_IDLE);
		return r;
	endfunction

	function automatic frame_item_t make_item(logic [2:0] op, int l, int t, int r, int b,
			int val, bit last, int rx, int ry);
		frame_item_t it;
		it.op = op;
		it.left = 16'(l);
		it.top = 16'(t);
		it.right = 16'(r);
		it.bottom = 16'(b);
		it.value = 16'(val);
		it.last = last;
		it.rx = 9'(rx);
		it.ry = 9'(ry);
		return it;
	endfunction

	// Drive one item, wait for its transfer, then queue the status it should produce.
	task automatic transfer_item(input frame_item_t it, input bit typed, input status_t fixed);
		status_t predicted;
		while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= it.op;
		rect_left <= it.left;
		rect_top <= it.top;
		rect_right <= it.right;
		rect_bottom <= it.bottom;
		pixel_value <= it.value;
		pixel_last <= it.last;
		read_x <= it.rx;
		read_y <= it.ry;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = mirror_step(it);
		if (typed)
			expected_status.push_back(fixed);
		else
			expected_status.push_back(predicted);
		if (counting && it.op <= OP_READ)
			random_items++;
	endtask

	task automatic send_op(logic [2:0] op);
		transfer_item(make_item(op, $urandom, $urandom, $urandom, $urandom, $urandom,
			1'($urandom), $urandom, $urandom), 1'b0, no_status);
	endtask

	task automatic send_read(int rx, int ry);
		transfer_item(make_item(OP_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
			1'($urandom), rx, ry), 1'b0, no_status);
	endtask

	// Fully random item of any operation, spare codes included.
	task automatic send_noise();
		send_op(3'($urandom));
	endtask

	// A run of pixels of one rectangle; the final one carries the last mark if asked.
	task automatic send_pixels(int l, int t, int r, int b, int cnt, bit ends);
		for (int i = 0; i < cnt; i++)
			transfer_item(make_item(OP_PIXEL, l, t, r, b, $urandom, ends && i == cnt - 1,
				$urandom, $urandom), 1'b0, no_status);
	endtask

	// A pixel of an empty source rectangle closes whatever rectangle is open.
	task automatic close_rect();
		int l, t;
		l = $urandom_range(1, 60);
		t = $urandom_range(0, 60);
		if ($urandom_range(0, 1))
			send_pixels(l, t, l - int'($urandom_range(1, 40)), t, 1,
				1'($urandom_range(0, 1)));
		else
			send_pixels(l, t, l, t - int'($urandom_range(1, 40)), 1,
				1'($urandom_range(0, 1)));
	endtask

	// Small rectangle near the frame, partly off screen at times.
	task automatic pick_rect(output int l, output int t, output int r, output int b,
			output int n);
		int rw, rh;
		rw = $urandom_range(1, 12);
		rh = $urandom_range(1, 4);
		l = int'($urandom_range(0, int'(mirror_width) + 3)) - 3;
		t = int'($urandom_range(0, int'(mirror_height) + 1)) - 2;
		r = l + rw - 1;
		b = t + rh - 1;
		n = rw * rh;
	endtask

	// One capture: request, arm (sometimes mid-rectangle), rectangles until ready,
	// read-back, thaw. Noise and broken rectangles are mixed in.
	task automatic capture_run(int max_rects);
		int l, t, r, b, n, k, rects, sel;
		repeat ($urandom_range(0, 3))
			send_noise();
		close_rect();
		send_op(OP_REQUEST);
		if ($urandom_range(0, 3) == 0) begin
			pick_rect(l, t, r, b, n);
			k = (n > 1) ? $urandom_range(1, n - 1) : 0;
			send_pixels(l, t, r, b, k, 1'b0);
			send_op(OP_ARM);
			send_pixels(l, t, r, b, n - k, 1'b1);
		end else begin
			send_op(OP_ARM);
		end
		rects = 0;
		while (mirror_phase == PH_ARMING && rects < max_rects) begin
			pick_rect(l, t, r, b, n);
			sel = $urandom_range(0, 19);
			if (sel == 0) begin
				send_pixels(l, t, r, b, $urandom_range(1, n), 1'b0);
				if ($urandom_range(0, 1))
					close_rect();
			end else if (sel == 1) begin
				send_noise();
			end else if (sel == 2) begin
				send_read($urandom, $urandom);
			end else begin
				send_pixels(l, t, r, b, n, 1'b1);
			end
			rects++;
		end
		repeat ($urandom_range(3, 10)) begin
			if ($urandom_range(0, 3) == 0)
				send_read($urandom, $urandom);
			else
				send_read($urandom_range(0, int'(mirror_width)),
					$urandom_range(0, int'(mirror_height)));
		end
		if ($urandom_range(0, 1))
			send_op(OP_REQUEST);
		if ($urandom_range(0, 3) == 0)
			send_op(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)));
		send_op(OP_THAW);
	endtask

	// Register write with the block drained: all results in, then a few cycles more.
	task automatic configure(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
		in_valid <= 1'b0;
		while (expected_status.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_FRAME_WIDTH)
			mirror_width = value;
		else if (idx == CFG_FRAME_HEIGHT)
			mirror_height = value;
	endtask

	// Directed row; typed rows carry a status read straight off the block's rules.
	task automatic note(logic [2:0] op, int l, int t, int r, int b, int val, bit last,
			int rx, int ry, bit typed, bit acc, phase_t st);
		plan_row_t row;
		row.it = make_item(op, l, t, r, b, val, last, rx, ry);
		row.typed = typed;
		row.fixed.acc = acc;
		row.fixed.st = st;
		row.fixed.rdy = (st == PH_READY);
		row.fixed.busy = (st != PH_IDLE);
		row.fixed.data = '0;
		opening_plan.push_back(row);
	endtask

	// Output side stalls at random while idling is on.
	always @(posedge clk) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= idle_on && ($urandom_range(0, 99) < IDLE_PCT);
	end

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h, actual %h", $time, name, want, got);
			failed = 1'b1;
		end
	endtask

	// Compare every result transfer with the oldest expected status.
	always @(posedge clk) begin : result_check
		status_t want;
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			if (expected_status.size() == 0) begin
				$display("%0t: unexpected result, accepted %b state %h data %h", $time,
					accepted, capture_state, read_data);
				failed = 1'b1;
			end else begin
				want = expected_status.pop_front();
				check_field("accepted", 16'(want.acc), 16'(accepted));
				check_field("capture_state", 16'(want.st), 16'(capture_state));
				check_field("capture_ready", 16'(want.rdy), 16'(capture_ready));
				check_field("capture_busy", 16'(want.busy), 16'(capture_busy));
				check_field("read_data", want.data, read_data);
			end
		end
	end

	// Watchdog: ends the run when no transfer of any kind happens for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Stimulus sequence.
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Reset geometry 320 x 240; store reads back as zero.
		note(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, PH_IDLE);
		note(OP_READ, 0, 0, 0, 0, 0, 0, 319, 239, 1, 1, PH_IDLE);
		note(OP_READ, 0, 0, 0, 0, 0, 0, 320, 0, 1, 0, PH_IDLE);
		note(OP_READ, 0, 0, 0, 0, 0, 0, 511, 511, 1, 0, PH_IDLE);
		note(OP_ARM, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, PH_IDLE);
		note(OP_PIXEL, 0, 0, 0, 0, 'hFFFF, 1, 0, 0, 1, 0, PH_IDLE);
		note(OP_SPARE_FIRST, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, PH_IDLE);
		note(OP_SPARE_LAST, -1, -1, -1, -1, 'hFFFF, 1, 511, 511, 1, 0, PH_IDLE);
		note(OP_THAW, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, PH_IDLE);
		note(OP_REQUEST, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, PH_REQUESTED);
		note(OP_REQUEST, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, PH_REQUESTED);
		// The cursor moves before arming, so the capture starts at column one.
		note(OP_PIXEL, 0, 0, 3, 0, 'h1234, 0, 0, 0, 0, 0, PH_IDLE);
		note(OP_ARM, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, PH_ARMING);
		note(OP_PIXEL, 0, 0, 3, 0, 'hFFFF, 0, 0, 0, 0, 0, PH_IDLE);
		note(OP_PIXEL, 0, 0, 3, 0, 'h0000, 0, 0, 0, 0, 0, PH_IDLE);
		note(OP_PIXEL, 0, 0, 3, 0, 'hA5A5, 1, 0, 0, 0, 0, PH_IDLE);
		// Empty source rectangle, rectangles that clip to nothing, then a wide row clipped to the frame.
		note(OP_PIXEL, 5, 5, 4, 5, 'h5A5A, 0, 0, 0, 1, 0, PH_ARMING);
		note(OP_PIXEL, -32768, -32768, -32768, -32768, 'h7FFF, 1, 0, 0, 1, 0, PH_ARMING);
		note(OP_PIXEL, 32767, 32767, 32767, 32767, 'h8000, 1, 0, 0, 1, 0, PH_ARMING);
		note(OP_PIXEL, -2, 0, 32767, 0, 'h1111, 1, 0, 0, 0, 0, PH_IDLE);
		// A tall column clips to the full height and completes the capture.
		note(OP_PIXEL, 0, 0, 0, 32767, 'h8001, 1, 0, 0, 0, 0, PH_IDLE);
		note(OP_PIXEL, 1, 1, 1, 1, 'h2222, 1, 0, 0, 1, 0, PH_READY);
		note(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, PH_IDLE);
		note(OP_READ, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, PH_IDLE);
		note(OP_REQUEST, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, PH_READY);
		note(OP_THAW, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, PH_IDLE);
		note(OP_READ, 0, 0, 0, 0, 0, 0, 3, 0, 0, 0, PH_IDLE);
		foreach (opening_plan[i])
			transfer_item(opening_plan[i].it, opening_plan[i].typed, opening_plan[i].fixed);

		// Extreme geometries: one pixel, zero sizes, sizes past the store, full size.
		counting = 1'b1;
		configure(CFG_FRAME_WIDTH, 10'd1);
		configure(CFG_FRAME_HEIGHT, 10'd1);
		repeat (3) capture_run(40);
		configure(CFG_FRAME_WIDTH, 10'd0);
		capture_run(3);
		configure(CFG_FRAME_WIDTH, 10'd5);
		configure(CFG_FRAME_HEIGHT, 10'd0);
		capture_run(3);
		configure(CFG_UNMAPPED, 10'($urandom));
		configure(CFG_FRAME_WIDTH, 10'd1023);
		configure(CFG_FRAME_HEIGHT, 10'd1023);
		capture_run(3);
		configure(CFG_FRAME_WIDTH, 10'd512);
		configure(CFG_FRAME_HEIGHT, 10'd512);
		capture_run(3);

		// Random frames, mostly small; the third setting runs with no idling at all.
		for (int ph = 0; random_items < RANDOM_ITEMS; ph++) begin
			if ($urandom_range(0, 5) == 0)
				configure(CFG_FRAME_WIDTH, 10'd512);
			else
				configure(CFG_FRAME_WIDTH, 10'($urandom_range(1, 24)));
			configure(CFG_FRAME_HEIGHT, 10'($urandom_range(1, 12)));
			idle_on = (ph != 2);
			repeat ($urandom_range(2, 4)) capture_run(40);
		end

		// Drain, then allow a few cycles for any stray result.
		in_valid <= 1'b0;
		while (expected_status.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (!failed)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/fcm_pkg.sv
hdl/fcm_ctrl.sv
hdl/fcm_store.sv
hdl/frame_capture_mirror_top.sv
verif/tb.sv
